// ===== hdl/block_pool_slice_allocator_assert.svh =====
// assertion macros for the slice allocator checker
`ifndef BLOCK_POOL_SLICE_ALLOCATOR_ASSERT_SVH
`define BLOCK_POOL_SLICE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BPSA_AST_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BPSA_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpsa_pkg.sv =====
`default_nettype none
package bpsa_pkg;

  localparam int BLOCK_SHIFT_DEF = 12;
  localparam int NUM_BLOCKS_DEF  = 16;

  localparam logic [3:0] TOP_LEVEL   = 4'd9;
  localparam logic [3:0] MARK_NIBBLE = 4'h1;   // marker byte is 16 | level

  // opcodes
  localparam logic [2:0] OP_NEW    = 3'd0;
  localparam logic [2:0] OP_GROW   = 3'd1;
  localparam logic [2:0] OP_WRITE  = 3'd2;
  localparam logic [2:0] OP_READ   = 3'd3;
  localparam logic [2:0] OP_APPEND = 3'd4;
  localparam logic [2:0] OP_PREFIX = 3'd5;
  localparam logic [2:0] OP_RESET  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_LEVEL = 2'd2;

  typedef logic [3:0] asel_t;
  typedef logic [3:0] wsel_t;
  typedef logic [3:0] act_t;
  typedef logic [3:0] fin_t;

  // memory address sources
  localparam asel_t A_IN    = 4'd0;
  localparam asel_t A_M3    = 4'd1;
  localparam asel_t A_M2    = 4'd2;
  localparam asel_t A_M1    = 4'd3;
  localparam asel_t A_P1    = 4'd4;
  localparam asel_t A_START = 4'd5;
  localparam asel_t A_S1    = 4'd6;
  localparam asel_t A_S2    = 4'd7;
  localparam asel_t A_LAST  = 4'd8;
  localparam asel_t A_CLR   = 4'd9;

  // memory write data sources
  localparam wsel_t W_ZERO = 4'd0;
  localparam wsel_t W_DATA = 4'd1;
  localparam wsel_t W_T0   = 4'd2;
  localparam wsel_t W_T1   = 4'd3;
  localparam wsel_t W_T2   = 4'd4;
  localparam wsel_t W_S3   = 4'd5;
  localparam wsel_t W_S2   = 4'd6;
  localparam wsel_t W_S1   = 4'd7;
  localparam wsel_t W_S0   = 4'd8;
  localparam wsel_t W_MARK = 4'd9;

  // datapath actions
  localparam act_t ACT_NONE         = 4'd0;
  localparam act_t ACT_LOAD         = 4'd1;
  localparam act_t ACT_LEVEL        = 4'd2;
  localparam act_t ACT_RESERVE      = 4'd3;
  localparam act_t ACT_SAVE0        = 4'd4;
  localparam act_t ACT_SAVE1        = 4'd5;
  localparam act_t ACT_SAVE2        = 4'd6;
  localparam act_t ACT_B0           = 4'd7;
  localparam act_t ACT_CLR_INIT     = 4'd8;
  localparam act_t ACT_CLR_STEP     = 4'd9;
  localparam act_t ACT_RST_STATE    = 4'd10;
  localparam act_t ACT_APPEND_CLAIM = 4'd11;

  // result word selects
  localparam fin_t FIN_NONE  = 4'd0;
  localparam fin_t FIN_ZERO  = 4'd1;
  localparam fin_t FIN_FAIL1 = 4'd2;
  localparam fin_t FIN_FAIL2 = 4'd3;
  localparam fin_t FIN_START = 4'd4;
  localparam fin_t FIN_GROW  = 4'd5;
  localparam fin_t FIN_ADDR  = 4'd6;
  localparam fin_t FIN_READ  = 4'd7;
  localparam fin_t FIN_PFX1  = 4'd8;
  localparam fin_t FIN_PFX2  = 4'd9;

  typedef struct packed {
    logic  mem_rd;
    logic  mem_wr;
    asel_t asel;
    wsel_t wsel;
    act_t  act;
    fin_t  fin;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       bad;
    logic       fail;
    logic       b0_hi;
    logic       clr_done;
    logic       claimed;
    logic       out_busy;
  } sts_t;

  function automatic logic [3:0] next_level(input logic [3:0] lvl);
    logic [3:0] nl;
    if (lvl < TOP_LEVEL) nl = lvl + 4'd1;
    else nl = TOP_LEVEL;
    return nl;
  endfunction

  function automatic logic [7:0] level_size(input logic [3:0] lvl);
    logic [7:0] sz;
    case (lvl)
      4'd0: sz = 8'd5;
      4'd1: sz = 8'd14;
      4'd2: sz = 8'd20;
      4'd3: sz = 8'd30;
      4'd4: sz = 8'd40;
      4'd5: sz = 8'd40;
      4'd6: sz = 8'd80;
      4'd7: sz = 8'd80;
      4'd8: sz = 8'd120;
      4'd9: sz = 8'd200;
      default: sz = 8'd0;
    endcase
    return sz;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bpsa_ctrl.sv =====
`default_nettype none
module bpsa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire bpsa_pkg::sts_t sts,
  output bpsa_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_INIT = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_OP   = 5'd2;
  localparam logic [4:0] S_RES  = 5'd3;
  localparam logic [4:0] S_LVL  = 5'd4;
  localparam logic [4:0] S_GCHK = 5'd5;
  localparam logic [4:0] S_GRES = 5'd6;
  localparam logic [4:0] S_G2   = 5'd7;
  localparam logic [4:0] S_G3   = 5'd8;
  localparam logic [4:0] S_G4   = 5'd9;
  localparam logic [4:0] S_G5   = 5'd10;
  localparam logic [4:0] S_G6   = 5'd11;
  localparam logic [4:0] S_G7   = 5'd12;
  localparam logic [4:0] S_G8   = 5'd13;
  localparam logic [4:0] S_G9   = 5'd14;
  localparam logic [4:0] S_G10  = 5'd15;
  localparam logic [4:0] S_G11  = 5'd16;
  localparam logic [4:0] S_RD   = 5'd17;
  localparam logic [4:0] S_P1   = 5'd18;
  localparam logic [4:0] S_P2   = 5'd19;
  localparam logic [4:0] S_CLR  = 5'd20;

  logic [4:0] state_r, state_nxt;
  bpsa_pkg::cmd_t c;

  assign in_stall = (state_r != S_IDLE);

  // memory write helper
  function automatic bpsa_pkg::cmd_t wr(input bpsa_pkg::asel_t a,
                                        input bpsa_pkg::wsel_t w);
    bpsa_pkg::cmd_t r;
    r = '0;
    r.mem_wr = 1'b1;
    r.asel = a;
    r.wsel = w;
    return r;
  endfunction

  always_comb begin
    c = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: begin
        if (sts.clr_done) state_nxt = S_IDLE;
        else begin
          c = wr(bpsa_pkg::A_CLR, bpsa_pkg::W_ZERO);
          c.act = bpsa_pkg::ACT_CLR_STEP;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          c.act = bpsa_pkg::ACT_LOAD;
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        state_nxt = S_IDLE;
        case (sts.op)
          bpsa_pkg::OP_NEW, bpsa_pkg::OP_APPEND: begin
            c.act = bpsa_pkg::ACT_RESERVE;
            state_nxt = S_RES;
          end
          bpsa_pkg::OP_GROW: begin
            c.mem_rd = 1'b1;
            state_nxt = S_LVL;
          end
          bpsa_pkg::OP_WRITE: begin
            c = wr(bpsa_pkg::A_IN, bpsa_pkg::W_DATA);
            c.fin = bpsa_pkg::FIN_ADDR;
          end
          bpsa_pkg::OP_READ: begin
            c.mem_rd = 1'b1;
            state_nxt = S_RD;
          end
          bpsa_pkg::OP_PREFIX: begin
            c.mem_rd = 1'b1;
            state_nxt = S_P1;
          end
          bpsa_pkg::OP_RESET: begin
            if (sts.claimed) begin
              c.act = bpsa_pkg::ACT_CLR_INIT;
              state_nxt = S_CLR;
            end else c.fin = bpsa_pkg::FIN_ZERO;
          end
          default: c.fin = bpsa_pkg::FIN_ZERO;
        endcase
      end
      S_RES: begin
        state_nxt = S_IDLE;
        if (sts.fail) c.fin = bpsa_pkg::FIN_FAIL1;
        else if (sts.op == bpsa_pkg::OP_NEW) begin
          c = wr(bpsa_pkg::A_LAST, bpsa_pkg::W_MARK);
          c.fin = bpsa_pkg::FIN_START;
        end else begin
          c = wr(bpsa_pkg::A_START, bpsa_pkg::W_DATA);
          c.act = bpsa_pkg::ACT_APPEND_CLAIM;
          c.fin = bpsa_pkg::FIN_START;
        end
      end
      S_LVL: begin
        c.act = bpsa_pkg::ACT_LEVEL;
        state_nxt = S_GCHK;
      end
      S_GCHK: begin
        if (sts.bad) begin
          c.fin = bpsa_pkg::FIN_FAIL2;
          state_nxt = S_IDLE;
        end else begin
          c.act = bpsa_pkg::ACT_RESERVE;
          state_nxt = S_GRES;
        end
      end
      S_GRES: begin
        if (sts.fail) begin
          c.fin = bpsa_pkg::FIN_FAIL1;
          state_nxt = S_IDLE;
        end else begin
          c.mem_rd = 1'b1;
          c.asel = bpsa_pkg::A_M3;
          state_nxt = S_G2;
        end
      end
      S_G2: begin
        c.mem_rd = 1'b1;
        c.asel = bpsa_pkg::A_M2;
        c.act = bpsa_pkg::ACT_SAVE0;
        state_nxt = S_G3;
      end
      S_G3: begin
        c.mem_rd = 1'b1;
        c.asel = bpsa_pkg::A_M1;
        c.act = bpsa_pkg::ACT_SAVE1;
        state_nxt = S_G4;
      end
      S_G4: begin
        c = wr(bpsa_pkg::A_START, bpsa_pkg::W_T0);
        c.act = bpsa_pkg::ACT_SAVE2;
        state_nxt = S_G5;
      end
      S_G5: begin
        c = wr(bpsa_pkg::A_S1, bpsa_pkg::W_T1);
        state_nxt = S_G6;
      end
      S_G6: begin
        c = wr(bpsa_pkg::A_S2, bpsa_pkg::W_T2);
        state_nxt = S_G7;
      end
      S_G7: begin
        c = wr(bpsa_pkg::A_M3, bpsa_pkg::W_S3);
        state_nxt = S_G8;
      end
      S_G8: begin
        c = wr(bpsa_pkg::A_M2, bpsa_pkg::W_S2);
        state_nxt = S_G9;
      end
      S_G9: begin
        c = wr(bpsa_pkg::A_M1, bpsa_pkg::W_S1);
        state_nxt = S_G10;
      end
      S_G10: begin
        c = wr(bpsa_pkg::A_IN, bpsa_pkg::W_S0);
        state_nxt = S_G11;
      end
      S_G11: begin
        c = wr(bpsa_pkg::A_LAST, bpsa_pkg::W_MARK);
        c.fin = bpsa_pkg::FIN_GROW;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        c.fin = bpsa_pkg::FIN_READ;
        state_nxt = S_IDLE;
      end
      S_P1: begin
        if (!sts.b0_hi) begin
          c.fin = bpsa_pkg::FIN_PFX1;
          state_nxt = S_IDLE;
        end else begin
          c.mem_rd = 1'b1;
          c.asel = bpsa_pkg::A_P1;
          c.act = bpsa_pkg::ACT_B0;
          state_nxt = S_P2;
        end
      end
      S_P2: begin
        c.fin = bpsa_pkg::FIN_PFX2;
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        if (sts.clr_done) begin
          c.act = bpsa_pkg::ACT_RST_STATE;
          c.fin = bpsa_pkg::FIN_ZERO;
          state_nxt = S_IDLE;
        end else begin
          c = wr(bpsa_pkg::A_CLR, bpsa_pkg::W_ZERO);
          c.act = bpsa_pkg::ACT_CLR_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // hold a step that registers a result while the output register is still occupied
    if (c.fin != bpsa_pkg::FIN_NONE && sts.out_busy) begin
      c = '0;
      state_nxt = state_r;
    end
  end

  assign cmd = c;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_INIT;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/bpsa_dpath.sv =====
`default_nettype none
module bpsa_dpath #(
  parameter int BLOCK_SHIFT = bpsa_pkg::BLOCK_SHIFT_DEF,
  parameter int NUM_BLOCKS  = bpsa_pkg::NUM_BLOCKS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [2:0]     in_opcode,
  input  wire logic [15:0]    in_address,
  input  wire logic [7:0]     in_slice_size,
  input  wire logic [7:0]     in_data_byte,
  input  wire logic           in_zero_fill,
  input  wire logic           in_reuse_first,
  input  wire logic           out_stall,
  output logic                out_valid,
  output logic [15:0]         out_result_address,
  output logic [7:0]          out_read_data,
  output logic [14:0]         out_text_length,
  output logic [1:0]          out_status,
  input  wire bpsa_pkg::cmd_t cmd,
  output bpsa_pkg::sts_t      sts
);

  localparam int BLK  = 1 << BLOCK_SHIFT;
  localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int AW   = BLOCK_SHIFT + BW;
  localparam int PW   = AW + 1;
  localparam int XW   = ((AW > 16) ? AW : 16) + 1;
  localparam int FW   = BLOCK_SHIFT + 1;
  localparam int POOL = NUM_BLOCKS * BLK;

  logic [2:0]    op_r;
  logic [15:0]   addr_r;
  logic [7:0]    len_r, data_r;
  logic          zf_r, reuse_r;
  logic [3:0]    nl_r;
  logic          bad_r, fail_r;
  logic [BW-1:0] cur_r;
  logic          claimed_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] start_r;
  logic [7:0]    t0_r, t1_r, t2_r, b0_r;
  logic [PW-1:0] clr_ptr_r, clr_end_r;
  logic [7:0]    rdata_r;
  logic          rd_ok_r;
  logic          out_valid_r;
  logic [15:0]   res_addr_r;
  logic [7:0]    res_rdata_r;
  logic [14:0]   res_tlen_r;
  logic [1:0]    res_status_r;

  logic [7:0] mem_q [POOL];

  logic [XW-1:0] addr_x, start_x, maddr;
  logic          reach, acc_ok;
  logic [AW-1:0] midx;
  logic [7:0]    wdata, rdv;
  logic [31:0]   start32;

  // memory address and data selection
  assign addr_x  = XW'(addr_r);
  assign start_x = XW'(start_r);
  assign start32 = 32'(start_r);

  always_comb begin
    unique case (cmd.asel)
      bpsa_pkg::A_IN:    maddr = addr_x;
      bpsa_pkg::A_M3:    maddr = addr_x - XW'(3);
      bpsa_pkg::A_M2:    maddr = addr_x - XW'(2);
      bpsa_pkg::A_M1:    maddr = addr_x - XW'(1);
      bpsa_pkg::A_P1:    maddr = addr_x + XW'(1);
      bpsa_pkg::A_START: maddr = start_x;
      bpsa_pkg::A_S1:    maddr = start_x + XW'(1);
      bpsa_pkg::A_S2:    maddr = start_x + XW'(2);
      bpsa_pkg::A_LAST:  maddr = start_x + XW'(len_r) - XW'(1);
      bpsa_pkg::A_CLR:   maddr = XW'(clr_ptr_r);
      default:           maddr = addr_x;
    endcase
  end

  // only claimed blocks up to the current one are visible
  assign reach  = claimed_r && (maddr < XW'(POOL)) && (maddr[AW-1:BLOCK_SHIFT] <= cur_r);
  assign acc_ok = (cmd.asel == bpsa_pkg::A_CLR) || reach;
  assign midx   = acc_ok ? maddr[AW-1:0] : '0;

  always_comb begin
    unique case (cmd.wsel)
      bpsa_pkg::W_ZERO: wdata = 8'd0;
      bpsa_pkg::W_DATA: wdata = data_r;
      bpsa_pkg::W_T0:   wdata = t0_r;
      bpsa_pkg::W_T1:   wdata = t1_r;
      bpsa_pkg::W_T2:   wdata = t2_r;
      bpsa_pkg::W_S3:   wdata = start32[31:24];
      bpsa_pkg::W_S2:   wdata = start32[23:16];
      bpsa_pkg::W_S1:   wdata = start32[15:8];
      bpsa_pkg::W_S0:   wdata = start32[7:0];
      bpsa_pkg::W_MARK: wdata = {bpsa_pkg::MARK_NIBBLE, nl_r};
      default:          wdata = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && acc_ok) mem_q[midx] <= wdata;
    if (cmd.mem_rd) begin
      rdata_r <= mem_q[midx];
      rd_ok_r <= reach;
    end
  end

  assign rdv = rd_ok_r ? rdata_r : 8'd0;

  // bump reservation of len_r bytes
  logic [FW:0]   sum_f;
  logic          need, can;
  logic [BW:0]   cur_p1;
  logic [BW-1:0] cur_res;
  logic [FW-1:0] fill_base;
  logic [PW-1:0] end_full;
  logic [3:0]    lvl, nl;

  assign sum_f     = {1'b0, fill_r} + (FW+1)'(len_r);
  assign need      = !claimed_r || (sum_f > (FW+1)'(BLK));
  assign cur_p1    = {1'b0, cur_r} + (BW+1)'(1);
  assign can       = !claimed_r || (cur_p1 < (BW+1)'(NUM_BLOCKS));
  assign cur_res   = need ? (claimed_r ? cur_p1[BW-1:0] : '0) : cur_r;
  assign fill_base = need ? '0 : fill_r;
  assign end_full  = {cur_p1, {BLOCK_SHIFT{1'b0}}};
  assign lvl       = rdv[3:0];
  assign nl        = bpsa_pkg::next_level(lvl);

  always_ff @(posedge clk) begin
    case (cmd.act)
      bpsa_pkg::ACT_LOAD: begin
        op_r    <= in_opcode;
        addr_r  <= in_address;
        data_r  <= in_data_byte;
        zf_r    <= in_zero_fill;
        reuse_r <= in_reuse_first;
        nl_r    <= 4'd0;
        if (in_opcode == bpsa_pkg::OP_APPEND || in_slice_size == 8'd0) len_r <= 8'd1;
        else len_r <= in_slice_size;
      end
      bpsa_pkg::ACT_LEVEL: begin
        bad_r <= (lvl > bpsa_pkg::TOP_LEVEL);
        nl_r  <= nl;
        len_r <= bpsa_pkg::level_size(nl);
      end
      bpsa_pkg::ACT_RESERVE: begin
        fail_r  <= need && !can;
        start_r <= {cur_res, fill_base[BLOCK_SHIFT-1:0]};
      end
      bpsa_pkg::ACT_SAVE0: t0_r <= rdv;
      bpsa_pkg::ACT_SAVE1: t1_r <= rdv;
      bpsa_pkg::ACT_SAVE2: t2_r <= rdv;
      bpsa_pkg::ACT_B0:    b0_r <= rdv;
      default: ;
    endcase
  end

  // allocator state, clear walker and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      claimed_r   <= 1'b0;
      fill_r      <= FW'(BLK);
      clr_ptr_r   <= '0;
      clr_end_r   <= PW'(POOL);
      out_valid_r <= 1'b0;
    end else begin
      case (cmd.act)
        bpsa_pkg::ACT_RESERVE: begin
          if (!(need && !can)) begin
            cur_r     <= cur_res;
            claimed_r <= 1'b1;
            fill_r    <= fill_base + FW'(len_r);
          end
        end
        bpsa_pkg::ACT_APPEND_CLAIM: begin
          if (fill_r[BLOCK_SHIFT] && can) begin
            cur_r  <= cur_p1[BW-1:0];
            fill_r <= '0;
          end
        end
        bpsa_pkg::ACT_CLR_INIT: begin
          if (reuse_r && zf_r && cur_r == '0) begin
            clr_ptr_r <= '0;
            clr_end_r <= PW'(fill_r);
          end else if (reuse_r && !zf_r) begin
            clr_ptr_r <= PW'(BLK);
            clr_end_r <= end_full;
          end else begin
            clr_ptr_r <= '0;
            clr_end_r <= end_full;
          end
        end
        bpsa_pkg::ACT_CLR_STEP: clr_ptr_r <= clr_ptr_r + PW'(1);
        bpsa_pkg::ACT_RST_STATE: begin
          cur_r <= '0;
          if (reuse_r) fill_r <= '0;
          else begin
            claimed_r <= 1'b0;
            fill_r    <= FW'(BLK);
          end
        end
        default: ;
      endcase
      if (cmd.fin != bpsa_pkg::FIN_NONE) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin != bpsa_pkg::FIN_NONE) begin
      res_addr_r   <= 16'd0;
      res_rdata_r  <= 8'd0;
      res_tlen_r   <= 15'd0;
      res_status_r <= bpsa_pkg::ST_OK;
      case (cmd.fin)
        bpsa_pkg::FIN_FAIL1: res_status_r <= bpsa_pkg::ST_EXHAUSTED;
        bpsa_pkg::FIN_FAIL2: res_status_r <= bpsa_pkg::ST_BAD_LEVEL;
        bpsa_pkg::FIN_START: res_addr_r <= 16'(start_r);
        bpsa_pkg::FIN_GROW:  res_addr_r <= 16'(start_x + XW'(3));
        bpsa_pkg::FIN_ADDR:  res_addr_r <= addr_r;
        bpsa_pkg::FIN_READ: begin
          res_addr_r  <= addr_r;
          res_rdata_r <= rdv;
        end
        bpsa_pkg::FIN_PFX1: begin
          res_addr_r <= addr_r + 16'd1;
          res_tlen_r <= 15'(rdv);
        end
        bpsa_pkg::FIN_PFX2: begin
          res_addr_r <= addr_r + 16'd2;
          res_tlen_r <= {rdv, b0_r[6:0]};
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_address = res_addr_r;
  assign out_read_data      = res_rdata_r;
  assign out_text_length    = res_tlen_r;
  assign out_status         = res_status_r;

  assign sts.op       = op_r;
  assign sts.bad      = bad_r;
  assign sts.fail     = fail_r;
  assign sts.b0_hi    = rdv[7];
  assign sts.clr_done = (clr_ptr_r >= clr_end_r);
  assign sts.claimed  = claimed_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule
`default_nettype wire

// ===== hdl/block_pool_slice_allocator.sv =====
`default_nettype none
// Byte block pool with a bump slice allocator. Takes one command word at a time
// (new slice, grow slice, write, read, append, length prefix, reset) and returns
// one result word for each. All pool bytes sit in a single-port memory of
// NUM_BLOCKS << BLOCK_SHIFT bytes; that one port sets the timing. Grow slice does
// the level read, three byte reads, then eight writes, one per cycle, the last
// held while a stalled result is still registered. Reset walks the range of bytes
// it clears at one byte per cycle. After rst_n the whole pool is zeroed first,
// with in_stall high. A new word is taken once the previous one's result is
// registered, even while out_stall holds that result.
module block_pool_slice_allocator #(
  parameter int BLOCK_SHIFT = bpsa_pkg::BLOCK_SHIFT_DEF,  // 8..15, block bytes log2
  parameter int NUM_BLOCKS  = bpsa_pkg::NUM_BLOCKS_DEF    // 1..256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // command word
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_slice_size,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_zero_fill,
  input  wire logic        in_reuse_first,
  // result word
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_result_address,
  output logic [7:0]       out_read_data,
  output logic [14:0]      out_text_length,
  output logic [1:0]       out_status
);

  bpsa_pkg::cmd_t cmd;   // sequencer step
  bpsa_pkg::sts_t sts;   // datapath flags

  // sequencer: at most one memory access per state
  bpsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // pool memory, allocator state and result register
  bpsa_dpath #(
    .BLOCK_SHIFT (BLOCK_SHIFT),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_address         (in_address),
    .in_slice_size      (in_slice_size),
    .in_data_byte       (in_data_byte),
    .in_zero_fill       (in_zero_fill),
    .in_reuse_first     (in_reuse_first),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_result_address (out_result_address),
    .out_read_data      (out_read_data),
    .out_text_length    (out_text_length),
    .out_status         (out_status),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
`default_nettype wire

// ===== hdl/bpsa_checker.sv =====
`default_nettype none
`include "block_pool_slice_allocator_assert.svh"
module bpsa_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] out_result_address,
  input wire logic [7:0]  out_read_data,
  input wire logic [14:0] out_text_length,
  input wire logic [1:0]  out_status
);

  // a held result word keeps its address and status
  `BPSA_AST_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_address) && $stable(out_status), "result word changed while stalled")

  // one word in flight: the port closes right after an accept
  `BPSA_AST_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second word taken while busy")

  // failures answer with all other fields zero
  `BPSA_AST_NOW(a_fail_zero, out_valid && out_status != bpsa_pkg::ST_OK, out_result_address == 16'd0 && out_read_data == 8'd0 && out_text_length == 15'd0, "failed word carries data")

  // a decoded length never comes with read data
  `BPSA_AST_NOW(a_len_vs_read, out_valid && out_text_length != 15'd0, out_read_data == 8'd0, "length and read data together")

endmodule

bind block_pool_slice_allocator bpsa_checker u_bpsa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_address (out_result_address),
  .out_read_data      (out_read_data),
  .out_text_length    (out_text_length),
  .out_status         (out_status)
);
`default_nettype wire
